>>> design/dtpf_pkg.sv
// Shared types, constants and helpers for the delimited text packet framer.
package dtpf_pkg;

  // Payload store depth per bank; a packet holds at most STORE_DEPTH-1 bytes
  localparam int STORE_DEPTH = 64;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int BANKS       = 2;
  localparam int ADDR_W      = PTR_W + 1;

  // Result field widths are fixed by the interface
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 6;

  // Output queue depth (power of two, pointers wrap)
  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_PW    = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

  // Command queue depth: one entry per store bank
  localparam int CMDQ_DEPTH = BANKS;
  localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // Configuration register indexes
  localparam logic [7:0] CFG_START_DELIM = 8'd0;
  localparam logic [7:0] CFG_END_DELIM   = 8'd1;

  // Reset values of the delimiters
  localparam logic [BYTE_W-1:0] START_DELIM_RST = 8'h5B;  // '['
  localparam logic [BYTE_W-1:0] END_DELIM_RST   = 8'h5D;  // ']'

  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LZ    = 8'h7A;

  // Store write port, front to back
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  // Drain command: which bank, how many bytes
  typedef struct packed {
    logic             bank;
    logic [PTR_W-1:0] len;
  } drain_cmd_t;

  // Drain finished: bank may be refilled
  typedef struct packed {
    logic valid;
    logic bank;
  } drain_done_t;

  // One result beat
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  len;
    logic              last;
  } out_beat_t;

  typedef enum logic {
    DR_IDLE,
    DR_RUN
  } drain_state_t;

  // Letters, digits, '.', '/', ':' and space
  function automatic logic allowed_char(input logic [BYTE_W-1:0] c);
    logic ok;
    ok = ((c >= CH_LA) && (c <= CH_LZ)) ||
         ((c >= CH_UA) && (c <= CH_UZ)) ||
         ((c >= CH_0)  && (c <= CH_9))  ||
         (c == CH_DOT) || (c == CH_SLASH) || (c == CH_COLON) || (c == CH_SPACE);
    return ok;
  endfunction

endpackage

>>> design/dtpf_front.sv
// Front end: config registers, byte classification, store writes, drain commands.
module dtpf_front import dtpf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [BYTE_W-1:0] cfg_data,
  input  logic              in_push,
  output logic              in_full,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output store_wr_t         store_wr,
  output logic              cmd_push,
  output drain_cmd_t        cmd,
  input  drain_done_t       drain_done
);

  logic [BYTE_W-1:0] start_r, end_r;
  logic              in_pkt_r, in_pkt_nxt;
  logic [PTR_W-1:0]  pos_r, pos_nxt;
  logic              bank_r, bank_nxt;
  logic [BANKS-1:0]  busy_r, busy_nxt;
  logic              accept;

  assign cfg_ready = 1'b1;

  // Hold off input while the bank being filled still waits for its drain
  assign in_full = busy_r[bank_r];
  assign accept  = in_push & ~in_full;

  // Delimiter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_DELIM_RST;
      end_r   <= END_DELIM_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_START_DELIM) start_r <= cfg_data;
      if (cfg_index == CFG_END_DELIM)   end_r   <= cfg_data;
    end
  end

  // Classify the accepted byte
  always_comb begin
    in_pkt_nxt    = in_pkt_r;
    pos_nxt       = pos_r;
    bank_nxt      = bank_r;
    store_wr.en   = 1'b0;
    store_wr.addr = {bank_r, pos_r};
    store_wr.data = in_rx_byte;
    cmd_push      = 1'b0;
    cmd.bank      = bank_r;
    cmd.len       = pos_r;
    if (accept) begin
      if (in_rx_byte == start_r) begin
        in_pkt_nxt = 1'b1;
        pos_nxt    = '0;
      end else if (in_rx_byte == end_r) begin
        // non-empty packet closes: hand the bank to the back end
        if (in_pkt_r && (pos_r != '0)) begin
          cmd_push = 1'b1;
          bank_nxt = ~bank_r;
        end
        in_pkt_nxt = 1'b0;
        pos_nxt    = '0;
      end else if (in_pkt_r) begin
        if (!allowed_char(in_rx_byte) || (pos_r == PTR_W'(STORE_DEPTH - 1))) begin
          in_pkt_nxt = 1'b0;
          pos_nxt    = '0;
        end else begin
          store_wr.en = 1'b1;
          pos_nxt     = pos_r + PTR_W'(1);
        end
      end
    end
  end

  // Bank ownership: set on hand-off, cleared when drained
  always_comb begin
    busy_nxt = busy_r;
    if (drain_done.valid) busy_nxt[drain_done.bank] = 1'b0;
    if (cmd_push)         busy_nxt[bank_r]          = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pkt_r <= 1'b0;
      pos_r    <= '0;
      bank_r   <= 1'b0;
      busy_r   <= '0;
    end else begin
      in_pkt_r <= in_pkt_nxt;
      pos_r    <= pos_nxt;
      bank_r   <= bank_nxt;
      busy_r   <= busy_nxt;
    end
  end

endmodule

>>> design/dtpf_cmdq.sv
// Short queue of drain commands between the front and back ends.
module dtpf_cmdq import dtpf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  drain_cmd_t push_cmd,
  input  logic       pop,
  output logic       valid,
  output drain_cmd_t head
);

  drain_cmd_t          q_r [CMDQ_DEPTH];
  logic [CMDQ_PW-1:0]  wp_r, rp_r;
  logic [CMDQ_CW-1:0]  cnt_r;

  // Never pushed when full: each entry owns a whole bank
  assign valid = (cnt_r != '0);
  assign head  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + CMDQ_PW'(1);
      if (pop)  rp_r <= rp_r + CMDQ_PW'(1);
      cnt_r <= cnt_r + CMDQ_CW'(push) - CMDQ_CW'(pop);
    end
  end

endmodule

>>> design/dtpf_back.sv
// Back end: banked payload store, drain sequencer and result queue.
module dtpf_back import dtpf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  store_wr_t          store_wr,
  input  logic               cmd_valid,
  input  drain_cmd_t         cmd,
  output logic               cmd_pop,
  output drain_done_t        drain_done,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [BYTE_W-1:0]  out_payload_byte,
  output logic [IDX_W-1:0]   out_byte_index,
  output logic [IDX_W-1:0]   out_packet_length,
  output logic               out_packet_last
);

  // Two banks of payload storage
  logic [BYTE_W-1:0] mem [BANKS * STORE_DEPTH];
  logic [BYTE_W-1:0] rdata_r;
  logic [ADDR_W-1:0] rd_addr;

  drain_state_t      state_r, state_nxt;
  logic              bank_r, bank_nxt;
  logic [PTR_W-1:0]  len_r, len_nxt;
  logic [PTR_W-1:0]  idx_r, idx_nxt;
  logic              issue, space;

  // Read in flight, with its beat fields
  logic              pend_r;
  logic [PTR_W-1:0]  pend_idx_r, pend_len_r;
  logic              pend_last_r;

  out_beat_t              fq_r [OFIFO_DEPTH];
  logic [OFIFO_PW-1:0]    wp_r, rp_r;
  logic [OFIFO_CW-1:0]    cnt_r;
  logic                   fq_push, fq_pop;
  out_beat_t              beat;

  assign rd_addr = {bank_r, idx_r};

  always_ff @(posedge clk) begin
    if (store_wr.en) mem[store_wr.addr] <= store_wr.data;
    rdata_r <= mem[rd_addr];
  end

  // Room for one more beat counting the read in flight
  assign space = ((cnt_r + OFIFO_CW'(pend_r)) < OFIFO_CW'(OFIFO_DEPTH));

  // Drain sequencer
  always_comb begin
    state_nxt        = state_r;
    bank_nxt         = bank_r;
    len_nxt          = len_r;
    idx_nxt          = idx_r;
    cmd_pop          = 1'b0;
    issue            = 1'b0;
    drain_done.valid = 1'b0;
    drain_done.bank  = bank_r;
    unique case (state_r)
      DR_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          bank_nxt  = cmd.bank;
          len_nxt   = cmd.len;
          idx_nxt   = '0;
          state_nxt = DR_RUN;
        end
      end
      DR_RUN: begin
        if (space) begin
          issue   = 1'b1;
          idx_nxt = idx_r + PTR_W'(1);
          if (idx_r == len_r - PTR_W'(1)) begin
            drain_done.valid = 1'b1;
            state_nxt        = DR_IDLE;
          end
        end
      end
      default: state_nxt = DR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DR_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= issue;
    end
  end

  always_ff @(posedge clk) begin
    bank_r <= bank_nxt;
    len_r  <= len_nxt;
    idx_r  <= idx_nxt;
    if (issue) begin
      pend_idx_r  <= idx_r;
      pend_len_r  <= len_r;
      pend_last_r <= (idx_r == len_r - PTR_W'(1));
    end
  end

  // Result queue
  assign fq_push   = pend_r;
  assign fq_pop    = out_pop & ~out_empty;
  assign out_empty = (cnt_r == '0);

  always_comb begin
    beat.data = rdata_r;
    beat.idx  = IDX_W'(pend_idx_r);
    beat.len  = IDX_W'(pend_len_r);
    beat.last = pend_last_r;
  end

  always_ff @(posedge clk) begin
    if (fq_push) fq_r[wp_r] <= beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (fq_push) wp_r <= wp_r + OFIFO_PW'(1);
      if (fq_pop)  rp_r <= rp_r + OFIFO_PW'(1);
      cnt_r <= cnt_r + OFIFO_CW'(fq_push) - OFIFO_CW'(fq_pop);
    end
  end

  assign out_payload_byte  = fq_r[rp_r].data;
  assign out_byte_index    = fq_r[rp_r].idx;
  assign out_packet_length = fq_r[rp_r].len;
  assign out_packet_last   = fq_r[rp_r].last;

endmodule

>>> design/delimited_text_packet_framer.sv
// Top level of the delimited text packet framer.
//
// Input side is a queue write port: a received byte is taken when in_push is
// high and in_full is low. The start delimiter opens a packet, allowed
// characters are stored, the end delimiter closes it and the stored bytes come
// out of the result queue one beat each, with index, length and a last flag.
// Results are read like a queue: a beat is shown while out_empty is low and
// leaves when out_pop is high.
// Delimiters are written over the cfg port (index 0 start, 1 end); cfg_ready
// is always high.
// Throughput: one input byte per cycle while in_full is low. The store has
// two banks, so one packet can be gathered while the previous one drains;
// in_full rises only when both banks hold closed packets not yet drained.
// After the end delimiter is taken, its drain command passes the command queue,
// the drain sequencer, the registered store read and the result queue before
// the first beat shows; beats then follow one per cycle while the queue has room.
// A stalled receiver fills the 4-entry result queue and then pauses the drain;
// nothing is lost. Reset (synchronous) restores the default delimiters, closes
// any open packet and empties both queues; no clearing pass is needed.
module delimited_text_packet_framer import dtpf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [BYTE_W-1:0]  cfg_data,
  input  logic               in_push,
  output logic               in_full,
  input  logic [BYTE_W-1:0]  in_rx_byte,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [BYTE_W-1:0]  out_payload_byte,
  output logic [IDX_W-1:0]   out_byte_index,
  output logic [IDX_W-1:0]   out_packet_length,
  output logic               out_packet_last
);

  store_wr_t   store_wr;
  logic        cmd_push, cmd_pop, cmd_valid;
  drain_cmd_t  cmd_in, cmd_head;
  drain_done_t drain_done;

  dtpf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_rx_byte (in_rx_byte),
    .store_wr   (store_wr),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in),
    .drain_done (drain_done)
  );

  dtpf_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .pop      (cmd_pop),
    .valid    (cmd_valid),
    .head     (cmd_head)
  );

  dtpf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .store_wr          (store_wr),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd_head),
    .cmd_pop           (cmd_pop),
    .drain_done        (drain_done),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_payload_byte  (out_payload_byte),
    .out_byte_index    (out_byte_index),
    .out_packet_length (out_packet_length),
    .out_packet_last   (out_packet_last)
  );

endmodule

>>> design/dtpf_checker.sv
// Port-level checks for the delimited text packet framer, bound to the top level.
module dtpf_checker import dtpf_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [7:0]         cfg_index,
  input logic [BYTE_W-1:0]  cfg_data,
  input logic               in_push,
  input logic               in_full,
  input logic [BYTE_W-1:0]  in_rx_byte,
  input logic               out_pop,
  input logic               out_empty,
  input logic [BYTE_W-1:0]  out_payload_byte,
  input logic [IDX_W-1:0]   out_byte_index,
  input logic [IDX_W-1:0]   out_packet_length,
  input logic               out_packet_last
);

  // Reset empties the result queue and frees both banks
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("result queue or input stall survives reset");

  // Last flag marks exactly the final index of the packet
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_packet_last == (out_byte_index == out_packet_length - IDX_W'(1))))
    else $error("last flag disagrees with index and length");

  // Index stays inside the packet
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_byte_index < out_packet_length))
    else $error("byte index beyond packet length");

  // Beats of one packet come in order
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_packet_last) ##1 !out_empty
      |-> (out_byte_index == IDX_W'($past(out_byte_index, 1) + IDX_W'(1))))
    else $error("beat index does not follow the previous beat");

  // A stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_payload_byte)))
    else $error("stalled result beat changed");

endmodule

bind delimited_text_packet_framer dtpf_checker u_dtpf_checker (.*);
